[hdl/spp_pkg.sv]
`default_nettype none
package spp_pkg;

    // Width of the remainder and divisor datapath in the division chain.
    localparam int DIV_W = 56;
    // Quotient bits: sixteen value bits plus one overflow bit on top.
    localparam int QUO_W = 17;
    // Number of cells in the division chain, one quotient bit each.
    localparam int NUM_CELLS = QUO_W;

    // Configuration register indexes.
    localparam logic [2:0] REG_PLAYER_X   = 3'd0;
    localparam logic [2:0] REG_PLAYER_Y   = 3'd1;
    localparam logic [2:0] REG_VIEW_DIR_X = 3'd2;
    localparam logic [2:0] REG_VIEW_DIR_Y = 3'd3;
    localparam logic [2:0] REG_PLANE_X    = 3'd4;
    localparam logic [2:0] REG_PLANE_Y    = 3'd5;
    localparam logic [2:0] REG_WIDTH      = 3'd6;
    localparam logic [2:0] REG_HEIGHT     = 3'd7;

    // One restoring-division lane.
    typedef struct packed {
        logic [DIV_W-1:0] rem;
        logic [DIV_W-1:0] dvs;
        logic [QUO_W-1:0] quo;
    } t_div_lane;

    // Everything that travels down the division chain for one sprite.
    typedef struct packed {
        t_div_lane lane_d;
        t_div_lane lane_c;
        t_div_lane lane_s;
        logic      det_zero;
        logic      neg_d;
        logic      neg_c;
    } t_div_item;

    // One quotient bit: compare, conditionally subtract, halve the divisor.
    function automatic t_div_lane div_step(input t_div_lane lane);
        t_div_lane res;
        logic      ge;
        ge      = (lane.rem >= lane.dvs);
        res.rem = ge ? (lane.rem - lane.dvs) : lane.rem;
        res.dvs = lane.dvs >> 1;
        res.quo = {lane.quo[QUO_W-2:0], ge};
        return res;
    endfunction

    // Magnitude of a sign-extended value.
    function automatic logic [DIV_W-1:0] mag(input logic signed [DIV_W-1:0] v);
        return v[DIV_W-1] ? DIV_W'(-v) : DIV_W'(v);
    endfunction

endpackage
`default_nettype wire

[hdl/spp_if.sv]
`default_nettype none
interface spp_in_if;
    logic        valid;
    logic        ready;
    logic [15:0] sprite_x;
    logic [15:0] sprite_y;
    modport source (output valid, output sprite_x, output sprite_y, input ready);
    modport sink (input valid, input sprite_x, input sprite_y, output ready);
endinterface

interface spp_out_if;
    logic               valid;
    logic               ready;
    logic               visible;
    logic signed [15:0] depth;
    logic signed [15:0] center_column;
    logic [13:0]        sprite_size;
    logic [14:0]        start_column;
    logic signed [15:0] end_column;
    logic [14:0]        start_row;
    logic signed [15:0] end_row;
    modport source (output valid, output visible, output depth, output center_column,
                    output sprite_size, output start_column, output end_column,
                    output start_row, output end_row, input ready);
    modport sink (input valid, input visible, input depth, input center_column,
                  input sprite_size, input start_column, input end_column,
                  input start_row, input end_row, output ready);
endinterface

interface spp_cfg_if;
    logic        valid;
    logic        ready;
    logic [2:0]  index;
    logic [15:0] data;
    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

[hdl/spp_front.sv]
`default_nettype none
module spp_front (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_valid,
    output logic                     o_ready,
    input  wire logic [15:0]         i_sprite_x,
    input  wire logic [15:0]         i_sprite_y,
    input  wire logic [15:0]         i_player_x,
    input  wire logic [15:0]         i_player_y,
    input  wire logic signed [15:0]  i_dir_x,
    input  wire logic signed [15:0]  i_dir_y,
    input  wire logic signed [15:0]  i_plane_x,
    input  wire logic signed [15:0]  i_plane_y,
    input  wire logic [12:0]         i_width,
    input  wire logic [12:0]         i_height,
    output logic                     o_valid,
    input  wire logic                i_ready,
    output spp_pkg::t_div_item       o_item
);
    import spp_pkg::*;

    logic r_va, r_vb, r_vc, r_vd, r_ve;
    logic rdy_a, rdy_b, rdy_c, rdy_d, rdy_e;

    logic signed [16:0] r_dx, r_dy;
    logic signed [32:0] r_p_diry_dx, r_p_dirx_dy, r_p_plx_dy, r_p_ply_dx;
    logic signed [31:0] r_p_plx_diry, r_p_ply_dirx;
    logic signed [32:0] r_det, r_det_d;
    logic signed [33:0] r_tnum, r_dnum, r_dnum_d;
    logic signed [47:0] r_nd, r_nc;
    logic signed [46:0] r_ns;
    t_div_item          r_item;

    logic signed [32:0] n_det;
    logic signed [34:0] n_sum;
    logic [DIV_W-1:0]   abs_det, abs_dnum;

    // A stage takes a new transaction when it is empty or its content moves on.
    assign rdy_e   = !r_ve || i_ready;
    assign rdy_d   = !r_vd || rdy_e;
    assign rdy_c   = !r_vc || rdy_d;
    assign rdy_b   = !r_vb || rdy_c;
    assign rdy_a   = !r_va || rdy_b;
    assign o_ready = rdy_a;
    assign o_valid = r_ve;
    assign o_item  = r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_va <= 1'b0;
            r_vb <= 1'b0;
            r_vc <= 1'b0;
            r_vd <= 1'b0;
            r_ve <= 1'b0;
        end else begin
            if (rdy_a) r_va <= i_valid;
            if (rdy_b) r_vb <= r_va;
            if (rdy_c) r_vc <= r_vb;
            if (rdy_d) r_vd <= r_vc;
            if (rdy_e) r_ve <= r_vd;
        end
    end

    // Offsets from the viewer.
    always_ff @(posedge i_clk) begin
        if (rdy_a && i_valid) begin
            r_dx <= $signed({1'b0, i_sprite_x}) - $signed({1'b0, i_player_x});
            r_dy <= $signed({1'b0, i_sprite_y}) - $signed({1'b0, i_player_y});
        end
    end

    // Partial products of the camera transform.
    always_ff @(posedge i_clk) begin
        if (rdy_b && r_va) begin
            r_p_diry_dx  <= i_dir_y * r_dx;
            r_p_dirx_dy  <= i_dir_x * r_dy;
            r_p_plx_dy   <= i_plane_x * r_dy;
            r_p_ply_dx   <= i_plane_y * r_dx;
            r_p_plx_diry <= i_plane_x * i_dir_y;
            r_p_ply_dirx <= i_plane_y * i_dir_x;
        end
    end

    assign n_det = 33'(r_p_plx_diry) - 33'(r_p_ply_dirx);

    // Determinant and the two camera-space numerators.
    always_ff @(posedge i_clk) begin
        if (rdy_c && r_vb) begin
            r_det  <= n_det;
            r_tnum <= 34'(r_p_diry_dx) - 34'(r_p_dirx_dy);
            r_dnum <= 34'(r_p_plx_dy) - 34'(r_p_ply_dx);
        end
    end

    assign n_sum = 35'(r_dnum) + 35'(r_tnum);

    // Dividends of the depth, center and size quotients.
    always_ff @(posedge i_clk) begin
        if (rdy_d && r_vc) begin
            r_nd     <= {r_dnum, 14'b0};
            r_nc     <= 48'($signed({1'b0, i_width[12:1]}) * n_sum);
            r_ns     <= 47'($signed({1'b0, i_height}) * r_det);
            r_det_d  <= r_det;
            r_dnum_d <= r_dnum;
        end
    end

    assign abs_det  = mag(DIV_W'(r_det_d));
    assign abs_dnum = mag(DIV_W'(r_dnum_d));

    // Magnitudes and signs; divisors are aligned to the overflow bit.
    always_ff @(posedge i_clk) begin
        if (rdy_e && r_vd) begin
            r_item.lane_d.rem <= mag(DIV_W'(r_nd));
            r_item.lane_d.dvs <= abs_det << 16;
            r_item.lane_d.quo <= '0;
            r_item.lane_c.rem <= mag(DIV_W'(r_nc));
            r_item.lane_c.dvs <= abs_dnum << 16;
            r_item.lane_c.quo <= '0;
            r_item.lane_s.rem <= mag(DIV_W'(r_ns));
            r_item.lane_s.dvs <= abs_dnum << 22;
            r_item.lane_s.quo <= '0;
            r_item.det_zero   <= (r_det_d == '0);
            r_item.neg_d      <= r_nd[47] ^ r_det_d[32];
            r_item.neg_c      <= r_nc[47] ^ r_dnum_d[33];
        end
    end

endmodule
`default_nettype wire

[hdl/spp_div_cell.sv]
`default_nettype none
module spp_div_cell (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_valid,
    output logic               o_ready,
    input  wire spp_pkg::t_div_item i_item,
    output logic               o_valid,
    input  wire logic          i_ready,
    output spp_pkg::t_div_item o_item
);
    import spp_pkg::*;

    logic      r_valid;
    t_div_item r_item;

    assign o_ready = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_item  = r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    // One quotient bit for each of the three divisions.
    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_item.lane_d   <= div_step(i_item.lane_d);
            r_item.lane_c   <= div_step(i_item.lane_c);
            r_item.lane_s   <= div_step(i_item.lane_s);
            r_item.det_zero <= i_item.det_zero;
            r_item.neg_d    <= i_item.neg_d;
            r_item.neg_c    <= i_item.neg_c;
        end
    end

endmodule
`default_nettype wire

[hdl/spp_back.sv]
`default_nettype none
module spp_back (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_valid,
    output logic               o_ready,
    input  wire spp_pkg::t_div_item i_item,
    input  wire logic [12:0]   i_width,
    input  wire logic [12:0]   i_height,
    spp_out_if.source          o_result
);
    import spp_pkg::*;

    logic               r_v1, r_v2, rdy1, rdy2;
    logic               r_vis1;
    logic signed [15:0] r_depth1, r_center1;
    logic [13:0]        r_size1;

    logic               r_vis;
    logic signed [15:0] r_depth, r_center, r_ecol, r_erow;
    logic [13:0]        r_size;
    logic [14:0]        r_scol, r_srow;

    logic               ovf_d, ovf_c, ovf_s, qpos, vis;
    logic [15:0]        mag_d, mag_c;
    logic signed [15:0] depth_sat, center_sat;
    logic [13:0]        size_sat;

    logic [12:0]        half;
    logic signed [16:0] srow_s, scol_s, ecol_s;
    logic [13:0]        erow_u;

    assign rdy2    = !r_v2 || o_result.ready;
    assign rdy1    = !r_v1 || rdy2;
    assign o_ready = rdy1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            if (rdy1) r_v1 <= i_valid;
            if (rdy2) r_v2 <= r_v1;
        end
    end

    // Saturate the quotients; the top quotient bit flags overflow.
    always_comb begin
        ovf_d = i_item.lane_d.quo[QUO_W-1];
        ovf_c = i_item.lane_c.quo[QUO_W-1];
        ovf_s = i_item.lane_s.quo[QUO_W-1];
        mag_d = i_item.lane_d.quo[15:0];
        mag_c = i_item.lane_c.quo[15:0];
        if (i_item.neg_d) begin
            depth_sat = (ovf_d || mag_d[15]) ? 16'sh8000 : 16'(-mag_d);
        end else begin
            depth_sat = (ovf_d || mag_d[15]) ? 16'sh7FFF : $signed(mag_d);
        end
        if (i_item.neg_c) begin
            center_sat = (ovf_c || mag_c[15]) ? 16'sh8000 : 16'(-mag_c);
        end else begin
            center_sat = (ovf_c || mag_c[15]) ? 16'sh7FFF : $signed(mag_c);
        end
        size_sat = (ovf_s || (|i_item.lane_s.quo[15:14])) ? 14'h3FFF
                                                            : i_item.lane_s.quo[13:0];
        qpos = !i_item.neg_d && (ovf_d || (mag_d != '0));
        vis  = !i_item.det_zero && qpos;
    end

    always_ff @(posedge i_clk) begin
        if (rdy1 && i_valid) begin
            r_vis1    <= vis;
            r_depth1  <= i_item.det_zero ? '0 : depth_sat;
            r_center1 <= vis ? center_sat : '0;
            r_size1   <= vis ? size_sat : '0;
        end
    end

    // Draw bounds around the center, clamped to the screen.
    always_comb begin
        half   = r_size1[13:1];
        srow_s = $signed({5'b0, i_height[12:1]}) - $signed({4'b0, half});
        erow_u = {2'b0, i_height[12:1]} + {1'b0, half};
        scol_s = 17'(r_center1) - $signed({4'b0, half});
        ecol_s = 17'(r_center1) + $signed({4'b0, half});
    end

    always_ff @(posedge i_clk) begin
        if (rdy2 && r_v1) begin
            r_vis    <= r_vis1;
            r_depth  <= r_depth1;
            r_center <= r_center1;
            r_size   <= r_size1;
            if (!r_vis1) begin
                r_srow <= '0;
                r_erow <= '0;
                r_scol <= '0;
                r_ecol <= '0;
            end else begin
                r_srow <= srow_s[16] ? '0 : srow_s[14:0];
                r_erow <= (erow_u >= {1'b0, i_height}) ? 16'({3'b0, i_height} - 16'd1)
                                                        : $signed({2'b0, erow_u});
                r_scol <= scol_s[16] ? '0 : scol_s[14:0];
                r_ecol <= (ecol_s >= $signed({4'b0, i_width}))
                          ? 16'({3'b0, i_width} - 16'd1) : ecol_s[15:0];
            end
        end
    end

    assign o_result.valid         = r_v2;
    assign o_result.visible       = r_vis;
    assign o_result.depth         = r_depth;
    assign o_result.center_column = r_center;
    assign o_result.sprite_size   = r_size;
    assign o_result.start_column  = r_scol;
    assign o_result.end_column    = r_ecol;
    assign o_result.start_row     = r_srow;
    assign o_result.end_row       = r_erow;

endmodule
`default_nettype wire

[hdl/raycaster_sprite_projection.sv]
// Pipeline from an accepted sprite to its result: 5 transform stages, 17 division
// cells and 2 output stages. Throughput: one sprite per cycle while the output is
// ready; the division chain holds one bit cell per quotient bit, so every stage
// then takes a new transaction each cycle.
// Reset (synchronous, active low) empties the pipeline and loads the default camera.
`default_nettype none
module raycaster_sprite_projection (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    spp_in_if.sink     i_sprite,
    spp_cfg_if.sink    i_cfg,
    spp_out_if.source  o_result
);
    import spp_pkg::*;

    logic [15:0]        r_player_x, r_player_y;
    logic signed [15:0] r_dir_x, r_dir_y, r_plane_x, r_plane_y;
    logic [12:0]        r_width, r_height;

    logic      c_valid [NUM_CELLS+1];
    logic      c_ready [NUM_CELLS+1];
    t_div_item c_item  [NUM_CELLS+1];

    // Configuration registers are always writable.
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_player_x <= 16'd0;
            r_player_y <= 16'd0;
            r_dir_x    <= 16'sd16384;
            r_dir_y    <= 16'sd0;
            r_plane_x  <= 16'sd0;
            r_plane_y  <= 16'sd10813;
            r_width    <= 13'd640;
            r_height   <= 13'd480;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                REG_PLAYER_X:   r_player_x <= i_cfg.data;
                REG_PLAYER_Y:   r_player_y <= i_cfg.data;
                REG_VIEW_DIR_X: r_dir_x    <= $signed(i_cfg.data);
                REG_VIEW_DIR_Y: r_dir_y    <= $signed(i_cfg.data);
                REG_PLANE_X:    r_plane_x  <= $signed(i_cfg.data);
                REG_PLANE_Y:    r_plane_y  <= $signed(i_cfg.data);
                REG_WIDTH:      r_width    <= i_cfg.data[12:0];
                REG_HEIGHT:     r_height   <= i_cfg.data[12:0];
                default: begin
                end
            endcase
        end
    end

    // Camera transform and divider setup.
    spp_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_sprite.valid),
        .o_ready    (i_sprite.ready),
        .i_sprite_x (i_sprite.sprite_x),
        .i_sprite_y (i_sprite.sprite_y),
        .i_player_x (r_player_x),
        .i_player_y (r_player_y),
        .i_dir_x    (r_dir_x),
        .i_dir_y    (r_dir_y),
        .i_plane_x  (r_plane_x),
        .i_plane_y  (r_plane_y),
        .i_width    (r_width),
        .i_height   (r_height),
        .o_valid    (c_valid[0]),
        .i_ready    (c_ready[0]),
        .o_item     (c_item[0])
    );

    // Chain of division cells, one quotient bit per cell.
    for (genvar g = 0; g < NUM_CELLS; g++) begin : g_cell
        spp_div_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (c_valid[g]),
            .o_ready (c_ready[g]),
            .i_item  (c_item[g]),
            .o_valid (c_valid[g+1]),
            .i_ready (c_ready[g+1]),
            .o_item  (c_item[g+1])
        );
    end

    // Saturation, bounds and output register.
    spp_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (c_valid[NUM_CELLS]),
        .o_ready  (c_ready[NUM_CELLS]),
        .i_item   (c_item[NUM_CELLS]),
        .i_width  (r_width),
        .i_height (r_height),
        .o_result (o_result)
    );

endmodule
`default_nettype wire
